// ----- rtl/waypoint_go_to_goal_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Waypoint controller assertion macros
// Shorthand for clocked assertions on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_GO_TO_GOAL_CONTROLLER_ASSERT_SVH
`define WAYPOINT_GO_TO_GOAL_CONTROLLER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define WGC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define WGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/wgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Waypoint controller package
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package wgc_pkg;

	localparam int MAX_GOALS_DEF    = 64;
	localparam int CORDIC_STEPS_DEF = 16;

	// CORDIC datapath widths: vector and angle accumulator (angle Q4.30)
	localparam int CW = 45;
	localparam int ZW = 34;

	localparam logic signed [16:0] PI_Q12     = 17'sd12868;
	localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [2:0] {
		CFG_GAIN_LIN  = 3'd0,
		CFG_GAIN_ANG  = 3'd1,
		CFG_LIMIT_LIN = 3'd2,
		CFG_LIMIT_ANG = 3'd3,
		CFG_REACH     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic               start;
		logic signed [33:0] y;
		logic signed [33:0] x;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] z;
	} cordic_rsp_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 34'sd843314857;
			5'd1:    r = 34'sd497837829;
			5'd2:    r = 34'sd263043837;
			5'd3:    r = 34'sd133525159;
			5'd4:    r = 34'sd67021687;
			5'd5:    r = 34'sd33543516;
			5'd6:    r = 34'sd16775851;
			5'd7:    r = 34'sd8388437;
			5'd8:    r = 34'sd4194283;
			5'd9:    r = 34'sd2097149;
			5'd10:   r = 34'sd1048576;
			5'd11:   r = 34'sd524288;
			5'd12:   r = 34'sd262144;
			5'd13:   r = 34'sd131072;
			5'd14:   r = 34'sd65536;
			5'd15:   r = 34'sd32768;
			5'd16:   r = 34'sd16384;
			5'd17:   r = 34'sd8192;
			5'd18:   r = 34'sd4096;
			5'd19:   r = 34'sd2048;
			5'd20:   r = 34'sd1024;
			5'd21:   r = 34'sd512;
			5'd22:   r = 34'sd256;
			5'd23:   r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/waypoint_go_to_goal_controller.sv -----
// ----------------------------------------------------------------------------
// Waypoint go-to-goal controller
// Proportional waypoint follower for a differential-drive robot.
// ----------------------------------------------------------------------------
// A load transaction (func = 0) stores one waypoint; new_list restarts the
// list first, and waypoints beyond MAX_GOALS are dropped. A tick transaction
// (func = 1) carries the pose and returns one command result. A tick runs
// ten products through one shared 18x18 multiplier, then the yaw and bearing
// angles through a single iterative CORDIC unit (normalization plus one
// rotation per cycle), with the square root running beside it. A degenerate
// orientation skips the yaw run, and a pose right on the goal cuts the
// bearing run short; the 17-step square root then sets the pace. in_stall
// stays high while a tick is in flight, and a result still waiting in the
// output register holds the next tick at its end. A finished result sits in
// the output register while the next transaction may already enter.
// Configuration writes are taken every cycle; write them only while idle.
// ----------------------------------------------------------------------------
module waypoint_go_to_goal_controller #(
	parameter int MAX_GOALS    = wgc_pkg::MAX_GOALS_DEF,
	parameter int CORDIC_STEPS = wgc_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic               new_list,
	input  logic signed [15:0] goal_x,
	input  logic signed [15:0] goal_y,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] linear_cmd,
	output logic signed [15:0] angular_cmd,
	output logic [6:0]         goal_index,
	output logic               goal_reached,
	output logic               mission_done,
	output logic               homing_active,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import wgc_pkg::*;

	localparam int AW   = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
	localparam int CNTW = $clog2(MAX_GOALS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_MUL, S_DEC, S_YAW, S_BEAR, S_ERR,
		S_MLIN, S_MANG, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] gain_lin_q, gain_ang_q;
	logic [14:0] lim_lin_q, lim_ang_q, reach_q;

	// list state
	logic [CNTW-1:0] count_q, cur_q, cnt_eff, cur_next;
	logic            done_q, homing_q, tick_homing_q;

	// tick operands and intermediate results
	logic signed [15:0] px_q, py_q, qx_q, qy_q, qz_q, qw_q;
	logic signed [16:0] dx_q, dy_q, err_q, err_raw;
	logic signed [15:0] gx, gy, yaw_q;
	logic [3:0]         k_q;
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] prod_q, lin_t, ang_t, lim_l, lim_a;
	logic [33:0]        d2_q;
	logic signed [33:0] qd_q, qc_q, mz_q, cy_q;
	logic signed [33:0] mz2, mz_abs;
	logic               degenerate;
	logic [16:0]        dist_q;
	logic               dist_ok_q;
	logic signed [15:0] lin_q, ang_q;

	// output register
	logic               out_valid_q;
	logic [31:0]        cur_ext;

	// RAM and shared units
	logic               ram_we;
	logic [31:0]        ram_rdata;
	logic               sq_start_q, sq_done;
	logic [16:0]        sq_root;
	cordic_req_t        cor_req_q;
	cordic_rsp_t        cor_rsp;

	logic accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Write at the fill count, or at zero when a new list starts.
	assign cnt_eff = new_list ? '0 : count_q;
	assign ram_we  = accept && (func == FUNC_LOAD) && (cnt_eff < CNTW'(MAX_GOALS));
	assign cur_next = cur_q + 1'b1;

	wgc_ram #(
		.WIDTH (32),
		.DEPTH (MAX_GOALS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_eff[AW-1:0]),
		.wdata ({goal_x, goal_y}),
		.raddr (cur_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	wgc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start_q),
		.radicand (d2_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	wgc_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req_q),
		.rsp    (cor_rsp)
	);

	// Homing ticks aim at the origin instead of a table entry.
	assign gx = tick_homing_q ? 16'sd0 : $signed(ram_rdata[31:16]);
	assign gy = tick_homing_q ? 16'sd0 : $signed(ram_rdata[15:0]);

	// Yaw is forced to zero near gimbal lock or for a null quaternion.
	assign mz2        = 34'(mz_q) <<< 1;
	assign mz_abs     = (mz2 < 0) ? -mz2 : mz2;
	assign degenerate = mz_abs >= 34'(qd_q);

	// Heading error, wrapped once into plus or minus pi.
	assign err_raw = 17'(cor_rsp.z) - 17'(yaw_q);

	assign lim_l = $signed({21'd0, lim_lin_q});
	assign lim_a = $signed({21'd0, lim_ang_q});
	assign lin_t = (prod_q + 36'sd512) >>> 10;
	assign ang_t = (prod_q + 36'sd2048) >>> 12;

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL: begin
				case (k_q)
					4'd0: begin mul_a = 18'(dx_q); mul_b = 18'(dx_q); end
					4'd1: begin mul_a = 18'(dy_q); mul_b = 18'(dy_q); end
					4'd2: begin mul_a = 18'(qx_q); mul_b = 18'(qx_q); end
					4'd3: begin mul_a = 18'(qy_q); mul_b = 18'(qy_q); end
					4'd4: begin mul_a = 18'(qz_q); mul_b = 18'(qz_q); end
					4'd5: begin mul_a = 18'(qw_q); mul_b = 18'(qw_q); end
					4'd6: begin mul_a = 18'(qx_q); mul_b = 18'(qz_q); end
					4'd7: begin mul_a = 18'(qw_q); mul_b = 18'(qy_q); end
					4'd8: begin mul_a = 18'(qx_q); mul_b = 18'(qy_q); end
					4'd9: begin mul_a = 18'(qw_q); mul_b = 18'(qz_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_MLIN: begin
				mul_a = $signed({2'b00, gain_lin_q});
				mul_b = $signed({1'b0, dist_q});
			end
			S_MANG: begin
				mul_a = $signed({2'b00, gain_ang_q});
				mul_b = 18'(err_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gain_lin_q  <= 16'd2048;
			gain_ang_q  <= 16'd4096;
			lim_lin_q   <= 15'd819;
			lim_ang_q   <= 15'd2048;
			reach_q     <= 15'd102;
			count_q     <= '0;
			cur_q       <= '0;
			done_q      <= 1'b0;
			homing_q    <= 1'b0;
			out_valid_q <= 1'b0;
			sq_start_q  <= 1'b0;
			dist_ok_q   <= 1'b0;
			cor_req_q   <= '0;
		end else begin
			sq_start_q      <= 1'b0;
			cor_req_q.start <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_GAIN_LIN:  gain_lin_q <= cfg_data;
					CFG_GAIN_ANG:  gain_ang_q <= cfg_data;
					CFG_LIMIT_LIN: lim_lin_q  <= cfg_data[14:0];
					CFG_LIMIT_ANG: lim_ang_q  <= cfg_data[14:0];
					CFG_REACH:     reach_q    <= cfg_data[14:0];
					default: ;
				endcase
			end

			// drop the result once the consumer takes it
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (sq_done) begin
				dist_q    <= sq_root;
				dist_ok_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_LOAD) begin
							if (new_list) begin
								cur_q  <= '0;
								done_q <= 1'b0;
							end
							if (ram_we) begin
								count_q <= cnt_eff + 1'b1;
							end else begin
								count_q <= cnt_eff;
							end
						end else begin
							px_q          <= pose_x;
							py_q          <= pose_y;
							qx_q          <= quat_x;
							qy_q          <= quat_y;
							qz_q          <= quat_z;
							qw_q          <= quat_w;
							tick_homing_q <= (count_q == '0) || done_q;
							state_q       <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					dx_q    <= 17'(gx) - 17'(px_q);
					dy_q    <= 17'(gy) - 17'(py_q);
					k_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					// fold in the product issued in the previous cycle
					case (k_q)
						4'd1:  d2_q <= 34'(prod_q);
						4'd2:  d2_q <= d2_q + 34'(prod_q);
						4'd3: begin
							qd_q <= 34'(prod_q);
							qc_q <= 34'(prod_q);
						end
						4'd4: begin
							qd_q <= qd_q + 34'(prod_q);
							qc_q <= qc_q - 34'(prod_q);
						end
						4'd5: begin
							qd_q <= qd_q + 34'(prod_q);
							qc_q <= qc_q - 34'(prod_q);
						end
						4'd6: begin
							qd_q <= qd_q + 34'(prod_q);
							qc_q <= qc_q + 34'(prod_q);
						end
						4'd7:  mz_q <= 34'(prod_q);
						4'd8:  mz_q <= mz_q - 34'(prod_q);
						4'd9:  cy_q <= 34'(prod_q);
						4'd10: cy_q <= cy_q + 34'(prod_q);
						default: ;
					endcase
					k_q <= k_q + 1'b1;
					if (k_q == 4'd10) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					sq_start_q <= 1'b1;
					dist_ok_q  <= 1'b0;
					cor_req_q.start <= 1'b1;
					if (degenerate) begin
						yaw_q       <= '0;
						cor_req_q.y <= 34'(dy_q);
						cor_req_q.x <= 34'(dx_q);
						state_q     <= S_BEAR;
					end else begin
						cor_req_q.y <= cy_q <<< 1;
						cor_req_q.x <= qc_q;
						state_q     <= S_YAW;
					end
				end
				S_YAW: begin
					if (cor_rsp.done) begin
						yaw_q           <= cor_rsp.z;
						cor_req_q.start <= 1'b1;
						cor_req_q.y     <= 34'(dy_q);
						cor_req_q.x     <= 34'(dx_q);
						state_q         <= S_BEAR;
					end
				end
				S_BEAR: begin
					if (cor_rsp.done) begin
						if (err_raw > PI_Q12) begin
							err_q <= err_raw - TWO_PI_Q12;
						end else if (err_raw < -PI_Q12) begin
							err_q <= err_raw + TWO_PI_Q12;
						end else begin
							err_q <= err_raw;
						end
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					// hold until the square root has landed
					if (dist_ok_q) begin
						state_q <= S_MLIN;
					end
				end
				S_MLIN: begin
					state_q <= S_MANG;
				end
				S_MANG: begin
					lin_q   <= (lin_t > lim_l) ? 16'(lim_l) : 16'(lin_t);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (ang_t > lim_a) begin
						ang_q <= 16'(lim_a);
					end else if (ang_t < -lim_a) begin
						ang_q <= 16'(-lim_a);
					end else begin
						ang_q <= 16'(ang_t);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// commit once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						goal_reached <= 1'b0;
						linear_cmd   <= lin_q;
						angular_cmd  <= ang_q;
						mission_done <= done_q;
						homing_active <= homing_q;
						cur_ext      <= 32'(cur_q);
						if (tick_homing_q) begin
							if (!(dist_q > {2'b00, reach_q})) begin
								linear_cmd    <= '0;
								angular_cmd   <= '0;
								homing_q      <= 1'b0;
								homing_active <= 1'b0;
							end
						end else if (dist_q < {2'b00, reach_q}) begin
							goal_reached <= 1'b1;
							cur_q        <= cur_next;
							cur_ext      <= 32'(cur_next);
							if (cur_next >= count_q) begin
								done_q        <= 1'b1;
								homing_q      <= 1'b1;
								mission_done  <= 1'b1;
								homing_active <= 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign goal_index = cur_ext[6:0];

endmodule

// ----- rtl/wgc_ram.sv -----
// ----------------------------------------------------------------------------
// Waypoint controller RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wgc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/wgc_isqrt.sv -----
// ----------------------------------------------------------------------------
// Waypoint controller integer square root
// Restoring bit-pair square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wgc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] radicand,
	output logic        done,
	output logic [16:0] root
);
	logic        busy_q;
	logic [33:0] v_q;
	logic [34:0] r_q;
	logic [33:0] bit_q;
	logic [34:0] trial;

	assign trial = r_q + {1'b0, bit_q};
	assign root  = r_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				v_q    <= radicand;
				r_q    <= '0;
				bit_q  <= 34'h1_0000_0000;
			end else if (busy_q) begin
				if ({1'b0, v_q} >= trial) begin
					v_q <= 34'({1'b0, v_q} - trial);
					r_q <= (r_q >> 1) + {1'b0, bit_q};
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				// last bit pair handled: result is final next cycle
				if (bit_q == 34'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/wgc_cordic.sv -----
// ----------------------------------------------------------------------------
// Waypoint controller CORDIC arctangent
// Vectoring-mode atan2 with iterative normalization and one rotation a cycle.
// ----------------------------------------------------------------------------
module wgc_cordic #(
	parameter int STEPS = wgc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wgc_pkg::cordic_req_t req,
	output wgc_pkg::cordic_rsp_t rsp
);
	import wgc_pkg::*;

	localparam int IW = $clog2(STEPS + 1);
	localparam logic signed [CW-1:0] LIM40 = CW'(64'd1 << 40);
	localparam logic signed [CW-1:0] LIM36 = CW'(64'd1 << 36);
	localparam logic signed [ZW-1:0] RND   = ZW'(64'd1 << 17);

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_DONE} cst_t;

	cst_t                 state_q;
	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, z_rnd, ang;
	logic [IW-1:0]        i_q;
	logic                 small4, small1;
	logic signed [15:0]   z_out_q;
	logic                 done_q;

	assign small4 = (x_q > -LIM36) && (x_q < LIM36) && (y_q > -LIM36) && (y_q < LIM36);
	assign small1 = (x_q > -LIM40) && (x_q < LIM40) && (y_q > -LIM40) && (y_q < LIM40);
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign ang    = atan_q30(5'(i_q));
	assign z_rnd  = z_q + RND;

	assign rsp.done = done_q;
	assign rsp.z    = z_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (req.start) begin
						if (req.x == '0 && req.y == '0) begin
							z_out_q <= '0;
							done_q  <= 1'b1;
						end else begin
							x_q     <= CW'(req.x);
							y_q     <= CW'(req.y);
							state_q <= C_NORM;
						end
					end
				end
				C_NORM: begin
					if (small4) begin
						x_q <= x_q <<< 4;
						y_q <= y_q <<< 4;
					end else if (small1) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						// fold the left half plane into the right one
						if (x_q < 0) begin
							if (y_q >= 0) begin
								x_q <= y_q;
								y_q <= -x_q;
								z_q <= HALF_PI_Q30;
							end else begin
								x_q <= -y_q;
								y_q <= x_q;
								z_q <= -HALF_PI_Q30;
							end
						end else begin
							z_q <= '0;
						end
						i_q     <= '0;
						state_q <= C_ROT;
					end
				end
				C_ROT: begin
					if (y_q >= 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + ang;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - ang;
					end
					i_q <= i_q + 1'b1;
					if (i_q == IW'(STEPS - 1)) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					z_out_q <= 16'(z_rnd >>> 18);
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/wgc_checker.sv -----
// ----------------------------------------------------------------------------
// Waypoint controller port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "waypoint_go_to_goal_controller_assert.svh"

module wgc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               func,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] linear_cmd,
	input logic               goal_reached,
	input logic               mission_done,
	input logic               homing_active
);
	// a stalled result stays offered
	`WGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// an accepted tick keeps the input stalled in the following cycle
	`WGC_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && func, in_stall, "tick did not stall input")

	// forward command is never negative
	`WGC_ASSERT_NOW(a_lin_pos, out_valid, !linear_cmd[15], "negative linear command")

	// finishing the last waypoint starts homing
	`WGC_ASSERT_NOW(a_done_homing, out_valid && goal_reached && mission_done, homing_active, "mission done without homing")
endmodule

bind waypoint_go_to_goal_controller wgc_checker u_wgc_checker (.*);
